[design/mcer_pkg.sv]
// mcer_pkg: shared widths, constants and types of the echo ranging core
// no dependencies; used by every module of the block by scoped names
package mcer_pkg;

   localparam int PIN_W      = 4;
   localparam int CH_W       = 2;
   localparam int COUNT_W    = 16;
   localparam int DIST_W     = 10;
   localparam int RANGE_W    = 9;
   localparam int AVG_W      = 9;

   localparam logic [RANGE_W-1:0] RANGE_RESET = 9'd400;

   localparam int CM_DIVISOR  = 58;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = 17;
   localparam int DIVISOR_W   = 6;

   localparam logic [RECIP_W-1:0] RECIP_CM = RECIP_W'((1 << RECIP_SHIFT) / CM_DIVISOR);

   typedef struct packed {
      logic [CH_W-1:0]    channel;
      logic [COUNT_W-1:0] count;
   } job_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic [CH_W-1:0]    channel;
      logic [COUNT_W-1:0] echo_count;
      logic [DIST_W-1:0]  distance_cm;
      logic               reading_rejected;
      logic [AVG_W-1:0]   average_cm;
   } result_type;

endpackage

[design/mcer_front.sv]
// mcer_front: per-tick pulse detection, channel selection and width counter
// depends on mcer_pkg; emits one job per finished echo pulse
module mcer_front #(
   parameter int NUM_LIVE = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [mcer_pkg::PIN_W-1:0]    echo_levels,
   input  logic [mcer_pkg::PIN_W-1:0]    listen_mask,
   output logic                          push,
   output mcer_pkg::job_type             push_job
);

   logic                         active_ff, active_in;
   logic [mcer_pkg::CH_W-1:0]    chan_ff, chan_in;
   logic [mcer_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [mcer_pkg::COUNT_W-1:0] count_inc;
   logic                         found;
   logic [mcer_pkg::CH_W-1:0]    found_ch;
   logic                         chan_done;

   // lowest listened high channel wins
   always_comb begin
      found    = 1'b0;
      found_ch = '0;
      for (int k = NUM_LIVE - 1; k >= 0; k--) begin
         if (echo_levels[k] && listen_mask[k]) begin
            found    = 1'b1;
            found_ch = mcer_pkg::CH_W'(k);
         end
      end
   end

   assign count_inc = count_ff + mcer_pkg::COUNT_W'(1);
   assign chan_done = listen_mask[chan_ff] && !echo_levels[chan_ff];

   always_comb begin
      active_in = active_ff;
      chan_in   = chan_ff;
      count_in  = count_ff;
      if (accept) begin
         if (!active_ff) begin
            if (found) begin
               active_in = 1'b1;
               chan_in   = found_ch;
               count_in  = '0;
            end
         end else begin
            count_in = count_inc;
            if (chan_done) begin
               active_in = 1'b0;
            end
         end
      end
   end

   assign push             = accept && active_ff && chan_done;
   assign push_job.channel = chan_ff;
   assign push_job.count   = count_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff  <= chan_in;
      count_ff <= count_in;
   end

endmodule

[design/mcer_queue.sv]
// mcer_queue: short job queue between the pulse front end and the ranging back end
// depends on mcer_pkg for the job and status types
module mcer_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mcer_pkg::job_type          push_job,
   input  logic                       pop,
   output mcer_pkg::job_type          pop_job,
   output mcer_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mcer_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + CNT_W'(1);
         2'b01:   fill_in = fill_ff - CNT_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   assign pop_job          = mem_ff[rd_ptr_ff];
   assign status.not_empty = (fill_ff != '0);
   assign status.full      = (fill_ff == CNT_W'(DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[design/mcer_back.sv]
// mcer_back: distance conversion, range check, history update and averaging
// depends on mcer_pkg; takes jobs from mcer_queue and holds the result register
module mcer_back #(
   parameter int NUM_LIVE      = 4,
   parameter int HISTORY_DEPTH = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cfg_write,
   input  logic [mcer_pkg::RANGE_W-1:0]  cfg_max_range,
   input  mcer_pkg::queue_status_type    q_status,
   input  mcer_pkg::job_type             q_job,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mcer_pkg::result_type          result
);

   localparam int ROW_W  = (NUM_LIVE > 1) ? $clog2(NUM_LIVE) : 1;
   localparam int IDX_W  = $clog2(HISTORY_DEPTH);
   localparam int SUM_W  = $clog2(HISTORY_DEPTH * ((1 << mcer_pkg::AVG_W) - 1) + 1);
   localparam int PROD_W = mcer_pkg::COUNT_W + mcer_pkg::RECIP_W;
   localparam int QD_W   = mcer_pkg::COUNT_W + mcer_pkg::DIVISOR_W;

   localparam logic [mcer_pkg::RECIP_W-1:0] RECIP_FULL =
      mcer_pkg::RECIP_W'((1 << mcer_pkg::RECIP_SHIFT) / HISTORY_DEPTH);
   localparam logic [mcer_pkg::RECIP_W-1:0] RECIP_PART =
      mcer_pkg::RECIP_W'((1 << mcer_pkg::RECIP_SHIFT) / (HISTORY_DEPTH - 1));

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_QUOT = 3'd2;
   localparam logic [2:0] ST_FIX  = 3'd3;
   localparam logic [2:0] ST_SUM  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [mcer_pkg::RANGE_W-1:0]   max_range_ff, max_range_in;
   mcer_pkg::job_type              job_ff, job_in;
   logic                           phase_ff, phase_in;
   logic                           rejected_ff, rejected_in;
   logic [mcer_pkg::DIST_W-1:0]    dist_ff, dist_in;
   logic [mcer_pkg::COUNT_W-1:0]   div_x_ff, div_x_in;
   logic [PROD_W-1:0]              prod_ff, prod_in;
   logic [mcer_pkg::COUNT_W-1:0]   quot_ff, quot_in;
   logic [QD_W-1:0]                qd_ff, qd_in;
   logic [SUM_W-1:0]               sum_ff, sum_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [mcer_pkg::AVG_W-1:0]     avg_ff, avg_in;
   logic [mcer_pkg::AVG_W-1:0]     hist_ff [NUM_LIVE][HISTORY_DEPTH];

   logic [mcer_pkg::RECIP_W-1:0]   recip;
   logic [mcer_pkg::DIVISOR_W-1:0] divisor;
   logic [mcer_pkg::COUNT_W-1:0]   quot_est;
   logic [QD_W-1:0]                rem;
   logic [mcer_pkg::COUNT_W-1:0]   fix_q;
   logic                           invalid;
   logic [mcer_pkg::DIST_W-1:0]    dist_val;
   logic                           reject_val;
   logic [ROW_W-1:0]               row;
   logic [mcer_pkg::AVG_W-1:0]     entry;
   logic                           hist_shift;

   // shared reciprocal divider: x * recip, then one correction step
   always_comb begin
      if (phase_ff) begin
         recip   = rejected_ff ? RECIP_PART : RECIP_FULL;
         divisor = rejected_ff ? mcer_pkg::DIVISOR_W'(HISTORY_DEPTH - 1)
                               : mcer_pkg::DIVISOR_W'(HISTORY_DEPTH);
      end else begin
         recip   = mcer_pkg::RECIP_CM;
         divisor = mcer_pkg::DIVISOR_W'(mcer_pkg::CM_DIVISOR);
      end
   end

   assign quot_est   = prod_ff[mcer_pkg::RECIP_SHIFT +: mcer_pkg::COUNT_W];
   assign rem        = QD_W'(div_x_ff) - qd_ff;
   assign fix_q      = quot_ff + mcer_pkg::COUNT_W'(rem >= QD_W'(divisor));
   assign invalid    = job_ff.count[mcer_pkg::COUNT_W-1];
   assign dist_val   = invalid ? '0 : mcer_pkg::DIST_W'(fix_q);
   assign reject_val = invalid || (dist_val > mcer_pkg::DIST_W'(max_range_ff));
   assign row        = job_ff.channel[ROW_W-1:0];
   assign entry      = hist_ff[row][idx_ff];
   assign hist_shift = (state_ff == ST_FIX) && !phase_ff;

   always_comb begin
      state_in     = state_ff;
      max_range_in = cfg_write ? cfg_max_range : max_range_ff;
      job_in       = job_ff;
      phase_in     = phase_ff;
      rejected_in  = rejected_ff;
      dist_in      = dist_ff;
      div_x_in     = div_x_ff;
      prod_in      = prod_ff;
      quot_in      = quot_ff;
      qd_in        = qd_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      avg_in       = avg_ff;
      pop          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_status.not_empty) begin
               pop      = 1'b1;
               job_in   = q_job;
               div_x_in = q_job.count;
               phase_in = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(div_x_ff) * PROD_W'(recip);
            state_in = ST_QUOT;
         end
         ST_QUOT: begin
            quot_in  = quot_est;
            qd_in    = QD_W'(quot_est) * QD_W'(divisor);
            state_in = ST_FIX;
         end
         ST_FIX: begin
            if (phase_ff) begin
               avg_in   = mcer_pkg::AVG_W'(fix_q);
               state_in = ST_OUT;
            end else begin
               dist_in     = dist_val;
               rejected_in = reject_val;
               sum_in      = '0;
               idx_in      = '0;
               state_in    = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in = sum_ff + SUM_W'(entry);
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_W'(HISTORY_DEPTH - 1)) begin
               div_x_in = mcer_pkg::COUNT_W'(sum_in);
               phase_in = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid               = (state_ff == ST_OUT);
   assign result.channel          = job_ff.channel;
   assign result.echo_count       = job_ff.count;
   assign result.distance_cm      = dist_ff;
   assign result.reading_rejected = rejected_ff;
   assign result.average_cm       = avg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_range_ff <= mcer_pkg::RANGE_RESET;
      end else begin
         state_ff     <= state_in;
         max_range_ff <= max_range_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      phase_ff    <= phase_in;
      rejected_ff <= rejected_in;
      dist_ff     <= dist_in;
      div_x_ff    <= div_x_in;
      prod_ff     <= prod_in;
      quot_ff     <= quot_in;
      qd_ff       <= qd_in;
      sum_ff      <= sum_in;
      idx_ff      <= idx_in;
      avg_ff      <= avg_in;
   end

   // history rows, newest entry at index zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_LIVE; r++) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
               hist_ff[r][i] <= '0;
            end
         end
      end else if (hist_shift) begin
         for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
            hist_ff[row][i] <= hist_ff[row][i-1];
         end
         hist_ff[row][0] <= reject_val ? '0 : dist_val[mcer_pkg::AVG_W-1:0];
      end
   end

endmodule

[design/multi_channel_echo_ranging_core.sv]
// multi_channel_echo_ranging_core: top level of the echo ranging block
// depends on mcer_pkg, mcer_front, mcer_queue and mcer_back
//
// Each request is one 1 us sample of up to four echo pins plus a listen mask. The front end
// takes one request every cycle while req_ready is high: it picks the lowest listened
// channel that goes high, counts the pulse width and, when that channel falls, hands the
// count to a two-entry job queue. The back end converts the count to centimetres (divide
// by 58), checks it against max_range_cm, updates that channel's history and returns the
// mean of the history. It handles one job at a time, holding the result until rsp_ready:
// two passes through a shared reciprocal divider (multiply, quotient, correction) and one
// history entry summed per cycle. req_ready drops only while the job queue is full, which
// happens when pulses end faster than the back end retires them or rsp_ready stays low.
// The max range register can be written at any cycle and applies at the next range check.
module multi_channel_echo_ranging_core #(
   parameter int NUM_CHANNELS  = 4,
   parameter int HISTORY_DEPTH = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mcer_pkg::PIN_W-1:0]    req_echo_levels,
   input  logic [mcer_pkg::PIN_W-1:0]    req_listen_mask,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mcer_pkg::CH_W-1:0]     rsp_channel,
   output logic [mcer_pkg::COUNT_W-1:0]  rsp_echo_count,
   output logic [mcer_pkg::DIST_W-1:0]   rsp_distance_cm,
   output logic                          rsp_reading_rejected,
   output logic [mcer_pkg::AVG_W-1:0]    rsp_average_cm,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mcer_pkg::RANGE_W-1:0]  csr_max_range_cm
);

   localparam int NUM_LIVE =
      (NUM_CHANNELS < mcer_pkg::PIN_W) ? NUM_CHANNELS : mcer_pkg::PIN_W;
   localparam int QUEUE_DEPTH = 2;

   logic                       req_accept;
   logic                       push;
   mcer_pkg::job_type          push_job;
   logic                       pop;
   mcer_pkg::job_type          pop_job;
   mcer_pkg::queue_status_type q_status;
   mcer_pkg::result_type       result;

   assign req_ready  = !q_status.full;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   mcer_front #(
      .NUM_LIVE (NUM_LIVE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .echo_levels (req_echo_levels),
      .listen_mask (req_listen_mask),
      .push        (push),
      .push_job    (push_job)
   );

   mcer_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   mcer_back #(
      .NUM_LIVE      (NUM_LIVE),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg_write     (csr_valid && csr_ready),
      .cfg_max_range (csr_max_range_cm),
      .q_status      (q_status),
      .q_job         (pop_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .result        (result)
   );

   assign rsp_channel          = result.channel;
   assign rsp_echo_count       = result.echo_count;
   assign rsp_distance_cm      = result.distance_cm;
   assign rsp_reading_rejected = result.reading_rejected;
   assign rsp_average_cm       = result.average_cm;

endmodule

[dv/tb_top.sv]
// tb_top: self-checking bench for multi_channel_echo_ranging_core
// depends on mcer_pkg and the core; keeps its own model of pulse timing and range history
`timescale 1ns / 1ps

module tb_top;

   localparam int CHANNELS      = 4;
   localparam int HIST          = 5;
   localparam int DRAIN_CYCLES  = 40;
   localparam int STALL_LIMIT   = 5000;
   localparam logic [mcer_pkg::COUNT_W-1:0] INVALID_COUNT = 16'd32768;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [mcer_pkg::PIN_W-1:0]     req_echo_levels = '0;
   logic [mcer_pkg::PIN_W-1:0]     req_listen_mask = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b1;
   logic [mcer_pkg::CH_W-1:0]      rsp_channel;
   logic [mcer_pkg::COUNT_W-1:0]   rsp_echo_count;
   logic [mcer_pkg::DIST_W-1:0]    rsp_distance_cm;
   logic                           rsp_reading_rejected;
   logic [mcer_pkg::AVG_W-1:0]     rsp_average_cm;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [mcer_pkg::RANGE_W-1:0]   csr_max_range_cm = '0;

   // model state
   logic [mcer_pkg::RANGE_W-1:0]   max_range_q;
   logic [2:0]                     active_q;
   logic [mcer_pkg::COUNT_W-1:0]   ticks_q;
   logic                           running_q;
   logic [mcer_pkg::AVG_W-1:0]     history_q [0:CHANNELS-1][0:HIST-1];

   mcer_pkg::result_type           expected_readings [$];
   mcer_pkg::result_type           got_reading;
   mcer_pkg::result_type           want_reading;
   int                             mismatch_count = 0;
   int                             quiet_cycles = 0;
   int                             phase_items;
   int                             phase_results;
   bit                             idling = 1'b1;

   always #1 clock = ~clock;

   multi_channel_echo_ranging_core #(
      .NUM_CHANNELS  (CHANNELS),
      .HISTORY_DEPTH (HIST)
   ) DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_echo_levels      (req_echo_levels),
      .req_listen_mask      (req_listen_mask),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_channel          (rsp_channel),
      .rsp_echo_count       (rsp_echo_count),
      .rsp_distance_cm      (rsp_distance_cm),
      .rsp_reading_rejected (rsp_reading_rejected),
      .rsp_average_cm       (rsp_average_cm),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_range_cm     (csr_max_range_cm)
   );

   task automatic reset_model();
      int c;
      int i;
      max_range_q = mcer_pkg::RANGE_RESET;
      active_q    = '0;
      ticks_q     = '0;
      running_q   = 1'b0;
      for (c = 0; c < CHANNELS; c++) begin
         for (i = 0; i < HIST; i++) begin
            history_q[c][i] = '0;
         end
      end
   endtask

   // one microsecond tick; returns 1 when a pulse ends and fills the reading
   function automatic bit predict_echo_tick(input logic [mcer_pkg::PIN_W-1:0] lv,
                                            input logic [mcer_pkg::PIN_W-1:0] mk,
                                            output mcer_pkg::result_type r);
      int k;
      int unsigned dist_cm;
      int unsigned sum;
      int unsigned num;
      bit rejected;
      bit started;
      logic [mcer_pkg::CH_W-1:0] ch;
      r = '0;
      started = 1'b0;
      if (running_q) ticks_q = ticks_q + 16'd1;
      if (active_q == 3'd0) begin
         for (k = 0; k < CHANNELS; k++) begin
            if (!started && lv[k] && mk[k]) begin
               started   = 1'b1;
               ticks_q   = '0;
               running_q = 1'b1;
               active_q  = 3'(k + 1);
            end
         end
         return 1'b0;
      end
      ch = mcer_pkg::CH_W'(active_q - 3'd1);
      if (!mk[ch] || lv[ch]) return 1'b0;
      dist_cm = (ticks_q >= INVALID_COUNT) ? 0 : ticks_q / mcer_pkg::CM_DIVISOR;
      rejected = (ticks_q >= INVALID_COUNT) || (dist_cm > max_range_q);
      active_q  = '0;
      running_q = 1'b0;
      for (k = HIST - 1; k > 0; k--) begin
         history_q[ch][k] = history_q[ch][k - 1];
      end
      history_q[ch][0] = rejected ? '0 : mcer_pkg::AVG_W'(dist_cm);
      sum = 0;
      num = 0;
      for (k = rejected ? 1 : 0; k < HIST; k++) begin
         sum += history_q[ch][k];
         num++;
      end
      r.channel          = ch;
      r.echo_count       = ticks_q;
      r.distance_cm      = mcer_pkg::DIST_W'(dist_cm);
      r.reading_rejected = rejected;
      r.average_cm       = mcer_pkg::AVG_W'(sum / num);
      return 1'b1;
   endfunction

   task automatic send_tick(input logic [mcer_pkg::PIN_W-1:0] lv,
                            input logic [mcer_pkg::PIN_W-1:0] mk);
      mcer_pkg::result_type r;
      if (idling && $urandom_range(0, 99) < 4) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_echo_levels <= lv;
      req_listen_mask <= mk;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      if (predict_echo_tick(lv, mk, r)) begin
         expected_readings.push_back(r);
         phase_results++;
      end
      phase_items++;
   endtask

   // well-formed echo on one channel giving exactly the given count (count >= 1)
   task automatic send_pulse(input int ch, input int unsigned count);
      logic [mcer_pkg::PIN_W-1:0] lv;
      logic [mcer_pkg::PIN_W-1:0] mk;
      int unsigned i;
      int j;
      if (active_q != 3'd0) send_tick(4'h0, 4'hF);
      mk = mcer_pkg::PIN_W'($urandom_range(0, 15)) | (4'b1 << ch);
      lv = mcer_pkg::PIN_W'($urandom_range(0, 15)) | (4'b1 << ch);
      for (j = 0; j < ch; j++) begin
         if (mk[j]) lv[j] = 1'b0;
      end
      send_tick(lv, mk);
      for (i = 1; i < count; i++) begin
         mk = mcer_pkg::PIN_W'($urandom_range(0, 15));
         lv = mcer_pkg::PIN_W'($urandom_range(0, 15));
         if (mk[ch]) lv[ch] = 1'b1;
         send_tick(lv, mk);
      end
      mk = mcer_pkg::PIN_W'($urandom_range(0, 15)) | (4'b1 << ch);
      lv = mcer_pkg::PIN_W'($urandom_range(0, 15)) & ~(4'b1 << ch);
      send_tick(lv, mk);
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_range(input logic [mcer_pkg::RANGE_W-1:0] value);
      settle_block();
      csr_valid        <= 1'b1;
      csr_max_range_cm <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      max_range_q = value;
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed_ticks();
      send_tick(4'h0, 4'h0); send_tick(4'h0, 4'hF); send_tick(4'hF, 4'h0);
      // priority: channel 0 wins, then channel 1 on the next idle tick
      send_tick(4'hF, 4'hF); send_tick(4'hE, 4'hF);
      send_tick(4'hE, 4'hF); send_tick(4'hC, 4'hF);
      // channel 3 alone, with unlisted ticks while active
      send_tick(4'h8, 4'h8); send_tick(4'h8, 4'h8); send_tick(4'h0, 4'h0);
      send_tick(4'h0, 4'h7); send_tick(4'h7, 4'h8);
      // high but unlisted pin does not start
      send_tick(4'h4, 4'hB);
      send_tick(4'h4, 4'h4); send_tick(4'h0, 4'hB); send_tick(4'hB, 4'hF);
      send_tick(4'h1, 4'h1); send_tick(4'h0, 4'h1);
   endtask

   task automatic test_range_limits();
      write_max_range(9'd0);
      send_pulse(0, 57);
      send_pulse(0, 58);
      write_max_range(9'd1);
      send_pulse(1, 116);
      send_pulse(1, 115);
      send_pulse(1, 59);
      write_max_range(9'd511);
      send_pulse(2, 300);
      send_pulse(0, 1);
   endtask

   task automatic test_long_pulses();
      write_max_range(9'd511);
      send_pulse(3, 360);
      send_pulse(2, 240);
      send_pulse(0, 1);
   endtask

   task automatic random_sequence();
      int unsigned pick;
      int unsigned len;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         repeat ($urandom_range(1, 6)) begin
            send_tick(mcer_pkg::PIN_W'($urandom_range(0, 15)),
                      mcer_pkg::PIN_W'($urandom_range(0, 15)));
         end
      end else begin
         if (pick < 75) len = $urandom_range(1, 40);
         else len = $urandom_range(1, 150);
         send_pulse($urandom_range(0, CHANNELS - 1), len);
      end
   endtask

   task automatic run_random_phase(input logic [mcer_pkg::RANGE_W-1:0] range_cm);
      write_max_range(range_cm);
      phase_items   = 0;
      phase_results = 0;
      while (phase_items < 60 || phase_results < 3) random_sequence();
   endtask

   task automatic test_random_traffic();
      run_random_phase(9'd400);
      run_random_phase(9'd0);
      run_random_phase(9'd511);
      run_random_phase(mcer_pkg::RANGE_W'($urandom_range(0, 7)));
      run_random_phase(mcer_pkg::RANGE_W'($urandom_range(0, 511)));
      run_random_phase(mcer_pkg::RANGE_W'($urandom_range(0, 3)));
   endtask

   task automatic test_full_rate();
      idling = 1'b0;
      run_random_phase(mcer_pkg::RANGE_W'($urandom_range(0, 15)));
   endtask

   // result side back-pressure
   always begin
      @(posedge clock);
      if (idling && $urandom_range(0, 99) < 5) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got_reading = {rsp_channel, rsp_echo_count, rsp_distance_cm,
                        rsp_reading_rejected, rsp_average_cm};
         if (expected_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected reading: ch=%0d count=%0d dist=%0d rej=%0b avg=%0d",
                        got_reading.channel, got_reading.echo_count,
                        got_reading.distance_cm, got_reading.reading_rejected,
                        got_reading.average_cm);
         end else begin
            want_reading = expected_readings.pop_front();
            if (got_reading !== want_reading) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("reading mismatch: expected ch=%0d count=%0d dist=%0d rej=%0b avg=%0d",
                           want_reading.channel, want_reading.echo_count,
                           want_reading.distance_cm, want_reading.reading_rejected,
                           want_reading.average_cm);
                  $display("                  got      ch=%0d count=%0d dist=%0d rej=%0b avg=%0d",
                           got_reading.channel, got_reading.echo_count,
                           got_reading.distance_cm, got_reading.reading_rejected,
                           got_reading.average_cm);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_ticks();
      test_range_limits();
      test_long_pulses();
      test_random_traffic();
      test_full_rate();
      settle_block();
      if (mismatch_count == 0 && expected_readings.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[files.f]
design/mcer_pkg.sv
design/mcer_front.sv
design/mcer_queue.sv
design/mcer_back.sv
design/multi_channel_echo_ranging_core.sv
dv/tb_top.sv
